@@ rtl/core/lpr_pkg.sv @@
// shared types and constants for the lru page replacement unit
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

   localparam int CAPACITY_DEFAULT  = 16;
   localparam int PAGE_BITS_DEFAULT = 20;

   localparam int CFG_W = 5;
   localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

   localparam int RSP_W = 8;

   typedef struct packed {
      logic cmp_en;
      logic upd_en;
      logic hit;
      logic miss_shift;
      logic valid;
   } lpr_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/lpr_cell.sv @@
// one stack cell: holds a resident page, compares it and shifts it towards the tail
`timescale 1ns / 1ps
`default_nettype none

module lpr_cell #(
   parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire lpr_pkg::lpr_ctrl_type ctrl,
   input  wire logic [PAGE_BITS-1:0] page,
   input  wire logic [PAGE_BITS-1:0] prev_entry,
   input  wire logic                 found_in,
   output logic                      found_out,
   output logic [PAGE_BITS-1:0]      entry_out
);

   logic [PAGE_BITS-1:0] entry_ff;
   logic [PAGE_BITS-1:0] entry_in;
   logic                 match_ff;
   logic                 match_in;
   logic                 shift;

   assign found_out = found_in | match_ff;
   assign entry_out = entry_ff;
   assign shift     = ctrl.hit ? ~found_in : ctrl.miss_shift;

   always_comb begin
      match_in = match_ff;
      if (ctrl.cmp_en) begin
         match_in = ctrl.valid && (entry_ff == page);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.upd_en && shift) begin
         entry_in = prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/lru_page_replacement_unit.sv @@
// top level of the lru page replacement unit
//
// req channel: one page reference per transaction, page number in the low
// bits of req_tdata. rsp channel: one fault flag per reference, in bit 0 of
// rsp_tdata, 1 when the page was not resident. csr channel: writes the
// table size (frames in use); zero acts as one, values above the built
// capacity act as the capacity. csr_wready is always high.
// a reference is compared against every cell in the cycle it is accepted;
// in the update state that follows, the hit/miss carry ripples down the
// row of cells and the stack shifts, the result landing in the output
// register. rsp_tvalid rises when that update completes, and a new
// reference is taken only after the update of the last one is done.
// a result waiting in the output register does not block acceptance of the
// next reference; that reference holds in its shift cycle until the
// receiver takes the earlier result.
// reset empties the stack (occupancy zero) and sets the table size to 16.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_replacement_unit #(
   parameter int CAPACITY  = lpr_pkg::CAPACITY_DEFAULT,
   parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEFAULT,
   localparam int REQ_W    = ((PAGE_BITS + 7) / 8) * 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_W-1:0]         req_tdata,   // page_number
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [lpr_pkg::RSP_W-1:0]     rsp_tdata,   // fault
   input  wire logic                     csr_wvalid,
   output logic                          csr_wready,
   input  wire logic [lpr_pkg::CFG_W-1:0] csr_wdata   // frames in use
);

   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int SZ_W  = (OCC_W > lpr_pkg::CFG_W) ? OCC_W : lpr_pkg::CFG_W;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_UPDATE = 1'b1;

   logic                      state_ff;
   logic                      state_in;
   logic [OCC_W-1:0]          occ_ff;
   logic [OCC_W-1:0]          occ_in;
   logic [lpr_pkg::CFG_W-1:0] frames_ff;
   logic [lpr_pkg::CFG_W-1:0] frames_in;
   logic [PAGE_BITS-1:0]      page_ff;
   logic [PAGE_BITS-1:0]      page_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      fault_ff;
   logic                      fault_in;

   logic                      req_accept;
   logic                      out_free;
   logic                      update;
   logic                      hit;
   logic [PAGE_BITS-1:0]      cmp_page;
   logic [SZ_W-1:0]           ts_ext;
   logic [SZ_W-1:0]           eff_size;
   logic [SZ_W-1:0]           occ_ext;
   logic [SZ_W-1:0]           miss_pos_w;
   logic [OCC_W-1:0]          miss_pos;

   logic [PAGE_BITS-1:0]      link [CAPACITY+1];
   logic                      found [CAPACITY+1];
   lpr_pkg::lpr_ctrl_type     ctrl [CAPACITY];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign update     = (state_ff == ST_UPDATE) && out_free;
   assign hit        = found[CAPACITY];
   assign cmp_page   = req_tdata[PAGE_BITS-1:0];
   assign csr_wready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(lpr_pkg::RSP_W-1)'(0), fault_ff};

   always_comb begin
      ts_ext  = SZ_W'(frames_ff);
      occ_ext = SZ_W'(occ_ff);
      if (ts_ext == '0) begin
         eff_size = SZ_W'(1);
      end else if (ts_ext > SZ_W'(CAPACITY)) begin
         eff_size = SZ_W'(CAPACITY);
      end else begin
         eff_size = ts_ext;
      end
      miss_pos_w = (occ_ext >= eff_size) ? (eff_size - SZ_W'(1)) : occ_ext;
      miss_pos   = OCC_W'(miss_pos_w);
   end

   assign found[0] = 1'b0;
   assign link[0]  = page_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      always_comb begin
         ctrl[i].cmp_en     = req_accept;
         ctrl[i].upd_en     = update;
         ctrl[i].hit        = hit;
         ctrl[i].miss_shift = (miss_pos >= OCC_W'(i));
         ctrl[i].valid      = (OCC_W'(i) < occ_ff);
      end

      lpr_cell #(
         .PAGE_BITS (PAGE_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl[i]),
         .page       (cmp_page),
         .prev_entry (link[i]),
         .found_in   (found[i]),
         .found_out  (found[i+1]),
         .entry_out  (link[i+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      frames_in    = frames_ff;
      page_in      = page_ff;
      rsp_valid_in = rsp_valid_ff;
      fault_in     = fault_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wvalid) begin
         frames_in = csr_wdata;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               page_in  = cmp_page;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               fault_in     = ~hit;
               state_in     = ST_IDLE;
               if (!hit) begin
                  occ_in = miss_pos + OCC_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         frames_ff    <= lpr_pkg::FRAMES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      page_ff  <= page_in;
      fault_ff <= fault_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/lpr_checker.sv @@
// port-level checks for the lru page replacement unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lpr_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [lpr_pkg::RSP_W-1:0] rsp_tdata
);

   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // reset leaves no result pending and the input open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   // one reference in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("second transaction accepted while busy");

   // a busy block with a free output delivers next cycle
   a_deliver: assert property (@(posedge clock) disable iff (reset)
      !req_tready && !rsp_tvalid |=> rsp_tvalid && req_tready)
      else $error("result not delivered");

   // fault flag is the only live bit
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[lpr_pkg::RSP_W-1:1] == '0))
      else $error("padding bits set in result");

endmodule

bind lru_page_replacement_unit lpr_checker u_lpr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
